[hw/rtl/wfd_pkg.sv]
`default_nettype none
package wfd_pkg;

   localparam int BUFFER_BYTES = 256;
   localparam int STORE_DEPTH  = BUFFER_BYTES / 4;
   localparam int IDX_W        = $clog2(STORE_DEPTH);
   localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
   localparam int RAM_DEPTH    = 2 * STORE_DEPTH;
   localparam int RAM_ADDR_W   = $clog2(RAM_DEPTH);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] TAG_RESET  = 16'hBEEF;
   localparam logic [31:0] TERM_RESET = 32'hDEADBEEF;

   localparam logic CFG_HEADER_TAG      = 1'b0;
   localparam logic CFG_TERMINATOR_WORD = 1'b1;

   typedef enum logic [2:0] {
      ST_PAYLOAD    = 3'd0,
      ST_EMPTY_OK   = 3'd1,
      ST_BAD_TERM   = 3'd2,
      ST_EARLY_TERM = 3'd3,
      ST_BAD_LEN    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_LOAD,
      BK_SHOW
   } back_state_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] nwords;
      logic [2:0]       last_bytes;
      logic             bank;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic bank;
   } release_type;

endpackage
`default_nettype wire

[hw/rtl/wfd_ram.sv]
`default_nettype none
module wfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/wfd_queue.sv]
`default_nettype none
module wfd_queue
   import wfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         head_valid
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/wfd_front.sv]
`default_nettype none
module wfd_front
   import wfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [31:0]           csr_wdata,
   input  wire logic                  q_full,
   output logic                       push,
   output cmd_type                    push_cmd,
   input  wire release_type           bank_release,
   output logic                       wr_en,
   output logic [RAM_ADDR_W-1:0]      wr_addr,
   output logic [31:0]                wr_data
);

   logic [15:0]      tag_ff;
   logic [31:0]      term_ff;
   logic [LEN_W-1:0] exp_ff;
   logic [LEN_W-1:0] cnt_ff;
   logic             bank_ff;
   logic [1:0]       busy_ff;
   logic [LEN_W-1:0] exp_in;
   logic [LEN_W-1:0] cnt_in;
   logic             bank_in;
   logic [1:0]       busy_in;
   logic             accept;
   logic [15:0]      len;
   logic [LEN_W:0]   cnt_plus;
   logic [LEN_W-1:0] pay;
   logic [LEN_W-1:0] pay_m1;
   logic [LEN_W:0]   pay_round;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full && !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign len        = req_tdata[15:0];
   assign cnt_plus   = {1'b0, cnt_ff} + (LEN_W+1)'(4);
   assign pay        = exp_ff - LEN_W'(4);
   assign pay_m1     = pay - LEN_W'(1);
   assign pay_round  = {1'b0, pay} + (LEN_W+1)'(3);
   assign wr_addr    = {bank_ff, cnt_ff[IDX_W+1:2]};
   assign wr_data    = req_tdata;

   always_comb begin
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      push     = 1'b0;
      push_cmd = '0;
      wr_en    = 1'b0;
      if (bank_release.done) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      if (accept) begin
         if (exp_ff == '0) begin
            if ((req_tdata[31:16] & tag_ff) == tag_ff && len != '0) begin
               if (len < 16'd4 || len > 16'(BUFFER_BYTES)) begin
                  push            = 1'b1;
                  push_cmd.status = ST_BAD_LEN;
               end else begin
                  exp_in = len[LEN_W-1:0];
                  cnt_in = '0;
               end
            end
         end else if (cnt_plus >= {1'b0, exp_ff}) begin
            exp_in = '0;
            cnt_in = '0;
            push   = 1'b1;
            if (req_tdata != term_ff) begin
               push_cmd.status = ST_BAD_TERM;
            end else if (pay == '0) begin
               push_cmd.status = ST_EMPTY_OK;
            end else begin
               push_cmd.status     = ST_PAYLOAD;
               push_cmd.nwords     = pay_round[IDX_W+1:2];
               push_cmd.last_bytes = 3'(pay_m1[1:0]) + 3'd1;
               push_cmd.bank       = bank_ff;
               busy_in[bank_ff]    = 1'b1;
               bank_in             = ~bank_ff;
            end
         end else if (req_tdata == term_ff) begin
            exp_in          = '0;
            cnt_in          = '0;
            push            = 1'b1;
            push_cmd.status = ST_EARLY_TERM;
         end else begin
            wr_en  = 1'b1;
            cnt_in = cnt_plus[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= TAG_RESET;
         term_ff <= TERM_RESET;
         exp_ff  <= '0;
         cnt_ff  <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         exp_ff  <= exp_in;
         cnt_ff  <= cnt_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_HEADER_TAG:      tag_ff  <= csr_wdata[15:0];
               CFG_TERMINATOR_WORD: term_ff <= csr_wdata;
               default:             ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

[hw/rtl/wfd_back.sv]
`default_nettype none
module wfd_back
   import wfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               head,
   input  wire logic                  head_valid,
   output logic                       pop,
   output logic [RAM_ADDR_W-1:0]      rd_addr,
   input  wire logic [31:0]           rd_data,
   output release_type                bank_release,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,  // payload_word, valid_bytes
   output logic [2:0]                 rsp_tuser,  // status
   output logic                       rsp_tlast
);

   back_state_type   state_ff;
   back_state_type   state_in;
   cmd_type          cmd_ff;
   cmd_type          cmd_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   status_type       status_ff;
   status_type       status_in;
   logic [31:0]      word_ff;
   logic [31:0]      word_in;
   logic [2:0]       bytes_ff;
   logic [2:0]       bytes_in;
   logic             last_ff;
   logic             last_in;
   logic             is_last;

   assign rd_addr    = {cmd_ff.bank, idx_ff};
   assign is_last    = idx_ff == cmd_ff.nwords - 1'b1;
   assign rsp_tvalid = state_ff == BK_SHOW;
   assign rsp_tdata  = {5'b0, bytes_ff, word_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      word_in      = word_ff;
      bytes_in     = bytes_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      bank_release = '0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cmd_in = head;
               idx_in = '0;
               if (head.status == ST_PAYLOAD) begin
                  state_in = BK_READ;
               end else begin
                  status_in = head.status;
                  word_in   = '0;
                  bytes_in  = '0;
                  last_in   = 1'b1;
                  state_in  = BK_SHOW;
               end
            end
         end
         BK_READ: begin
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            status_in = ST_PAYLOAD;
            word_in   = rd_data;
            bytes_in  = is_last ? cmd_ff.last_bytes : 3'd4;
            last_in   = is_last;
            state_in  = BK_SHOW;
         end
         BK_SHOW: begin
            if (rsp_tready) begin
               if (last_ff) begin
                  state_in = BK_IDLE;
                  if (status_ff == ST_PAYLOAD) begin
                     bank_release.done = 1'b1;
                     bank_release.bank = cmd_ff.bank;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      bytes_ff  <= bytes_in;
      last_ff   <= last_in;
   end

endmodule
`default_nettype wire

[hw/rtl/word_frame_deframer.sv]
// order: a closing word is registered in the command queue, then the back end moves a
//    status result straight to show, or replays a payload word by word through ram read,
//    load and show states, reading the next word only once the result side takes the last
// throughput: one link word per cycle; the front stalls only when the command queue
//    is full or the store bank it fills is still being replayed
// reset: control state cleared, header_tag 0xbeef, terminator_word 0xdeadbeef, no store clear
`default_nettype none
module word_frame_deframer
   import wfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // rx_word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // payload_word, valid_bytes
   output logic [2:0]       rsp_tuser,  // status
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                  q_full;
   logic                  push;
   cmd_type               push_cmd;
   logic                  pop;
   cmd_type               head;
   logic                  head_valid;
   release_type           bank_release;
   logic                  wr_en;
   logic [RAM_ADDR_W-1:0] wr_addr;
   logic [31:0]           wr_data;
   logic [RAM_ADDR_W-1:0] rd_addr;
   logic [31:0]           rd_data;

   wfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .push         (push),
      .push_cmd     (push_cmd),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   wfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   wfd_ram #(
      .WIDTH (32),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wfd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bank_release (bank_release),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_PAYLOAD |-> rsp_tlast && rsp_tdata == '0)
      else $error("status result carries payload or no last mark");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_PAYLOAD |->
         rsp_tdata[34:32] != 3'd0 && rsp_tdata[34:32] <= 3'd4)
      else $error("payload result with bad byte count");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("front accepts a transaction while the queue is full");

   a_release_payload: assert property (@(posedge clock) disable iff (reset)
      bank_release.done |-> rsp_tvalid && rsp_tready && rsp_tlast && rsp_tuser == ST_PAYLOAD)
      else $error("store bank released outside a final payload transaction");

endmodule
`default_nettype wire

[tb/sv/word_frame_deframer_tb.sv]
`timescale 1ns / 1ps
module word_frame_deframer_tb
   import wfd_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      status_type  status;
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } frame_reply_type;

   typedef struct packed {
      logic [31:0] word;
      logic        typed;
      status_type  status;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_wdata;

   logic [15:0] tag_cfg;
   logic [31:0] term_cfg;
   logic [8:0]  frame_len;
   logic [8:0]  rx_bytes;
   logic [31:0] payload_mem [STORE_DEPTH];

   frame_reply_type pending_replies [$];
   frame_reply_type fresh_replies [$];

   int error_count = 0;
   int cycle_count = 0;
   int busy_items = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   int stall_mode = 0;
   int ready_run = 0;
   logic ready_hold = 1'b1;

   dir_row_type script [21] = '{
      '{32'h0000_0000, 1'b0, ST_PAYLOAD},
      '{32'hBEEF_0000, 1'b0, ST_PAYLOAD},
      '{32'hBEEF_0001, 1'b1, ST_BAD_LEN},
      '{32'hBEEF_0003, 1'b1, ST_BAD_LEN},
      '{32'hBEEF_0101, 1'b1, ST_BAD_LEN},
      '{32'hFFFF_FFFF, 1'b1, ST_BAD_LEN},
      '{32'hBEEF_0004, 1'b0, ST_PAYLOAD},
      '{32'hDEAD_BEEF, 1'b1, ST_EMPTY_OK},
      '{32'hBEEF_0004, 1'b0, ST_PAYLOAD},
      '{32'h1234_5678, 1'b1, ST_BAD_TERM},
      '{32'hBEEF_000C, 1'b0, ST_PAYLOAD},
      '{32'hDEAD_BEEF, 1'b1, ST_EARLY_TERM},
      '{32'hBEEF_000D, 1'b0, ST_PAYLOAD},
      '{32'hBEEF_1234, 1'b0, ST_PAYLOAD},
      '{32'hFFFF_FFFF, 1'b0, ST_PAYLOAD},
      '{32'h0000_0000, 1'b0, ST_PAYLOAD},
      '{32'hDEAD_BEEF, 1'b0, ST_PAYLOAD},
      '{32'hFEFF_0006, 1'b0, ST_PAYLOAD},
      '{32'hA5A5_A5A5, 1'b0, ST_PAYLOAD},
      '{32'hDEAD_BEEF, 1'b0, ST_PAYLOAD},
      '{32'hBEEE_0008, 1'b0, ST_PAYLOAD}
   };

   word_frame_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic frame_reply_type status_reply(input status_type st);
      frame_reply_type r;
      r.status = st;
      r.word = '0;
      r.nbytes = '0;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic model_word(input logic [31:0] w);
      int len;
      int pay;
      int nwords;
      int left;
      frame_reply_type r;
      fresh_replies.delete();
      if (frame_len == 0) begin
         if ((w[31:16] & tag_cfg) != tag_cfg) return;
         len = int'(w[15:0]);
         if (len == 0) return;
         if (len < 4 || len > BUFFER_BYTES) begin
            fresh_replies.push_back(status_reply(ST_BAD_LEN));
            return;
         end
         frame_len = 9'(len);
         rx_bytes = '0;
         return;
      end
      if (int'(rx_bytes) + 4 >= int'(frame_len)) begin
         if (w != term_cfg) begin
            frame_len = '0;
            rx_bytes = '0;
            fresh_replies.push_back(status_reply(ST_BAD_TERM));
            return;
         end
         pay = int'(frame_len) - 4;
         nwords = (pay + 3) / 4;
         frame_len = '0;
         rx_bytes = '0;
         if (nwords == 0) begin
            fresh_replies.push_back(status_reply(ST_EMPTY_OK));
            return;
         end
         if (nwords > STORE_DEPTH - 1) nwords = STORE_DEPTH - 1;
         for (int i = 0; i < nwords; i++) begin
            left = pay - 4 * i;
            r.status = ST_PAYLOAD;
            r.word = payload_mem[i];
            r.nbytes = 3'((left > 4) ? 4 : left);
            r.last = (i + 1 == nwords);
            fresh_replies.push_back(r);
         end
         return;
      end
      if (w == term_cfg) begin
         frame_len = '0;
         rx_bytes = '0;
         fresh_replies.push_back(status_reply(ST_EARLY_TERM));
         return;
      end
      payload_mem[rx_bytes[7:2]] = w;
      rx_bytes = rx_bytes + 9'd4;
   endtask

   task automatic push_word(input logic [31:0] w, input logic typed, input status_type st);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      if (!(frame_len == 0 && (w[31:16] & tag_cfg) != tag_cfg)) busy_items++;
      model_word(w);
      if (typed) pending_replies.push_back(status_reply(st));
      else foreach (fresh_replies[i]) pending_replies.push_back(fresh_replies[i]);
      if (burst_left > 0) burst_left--;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CFG_HEADER_TAG) tag_cfg = data[15:0];
      else term_cfg = data;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic close_frame();
      while (frame_len != 0) push_word(term_cfg, 1'b0, ST_PAYLOAD);
   endtask

   task automatic send_frame();
      int r;
      int k;
      int len;
      int nw;
      int cut;
      logic [15:0] hi;
      logic [31:0] pw;
      logic [31:0] flip;
      r = $urandom_range(0, 99);
      hi = 16'($urandom) | tag_cfg;
      if (r < 8) begin
         push_word($urandom, 1'b0, ST_PAYLOAD);
         return;
      end
      if (r < 14) begin
         case ($urandom_range(0, 4))
            0: len = 0;
            1: len = $urandom_range(1, 3);
            2: len = BUFFER_BYTES + 1;
            3: len = 65535;
            default: len = $urandom_range(BUFFER_BYTES + 1, 65535);
         endcase
         push_word({hi, 16'(len)}, 1'b0, ST_PAYLOAD);
         return;
      end
      if (r < 16) len = BUFFER_BYTES;
      else if (r < 19) len = $urandom_range(41, BUFFER_BYTES);
      else len = $urandom_range(4, 40);
      push_word({hi, 16'(len)}, 1'b0, ST_PAYLOAD);
      nw = (len - 1) / 4;
      k = $urandom_range(0, 99);
      cut = (k < 6 && nw > 0) ? $urandom_range(0, nw - 1) : nw;
      for (int i = 0; i < cut; i++) begin
         pw = $urandom;
         if (pw == term_cfg) pw ^= 32'h1;
         push_word(pw, 1'b0, ST_PAYLOAD);
      end
      if (k >= 6 && k < 16) begin
         flip = $urandom;
         if (flip == 0) flip = 32'h1;
         push_word(term_cfg ^ flip, 1'b0, ST_PAYLOAD);
      end else begin
         push_word(term_cfg, 1'b0, ST_PAYLOAD);
      end
   endtask

   task automatic run_phase(input logic [15:0] tag, input logic [31:0] term, input int n,
                            input int mode, input bit gaps);
      int target;
      close_frame();
      wait_drained();
      csr_write(CFG_HEADER_TAG, {16'h0000, tag});
      csr_write(CFG_TERMINATOR_WORD, term);
      csr_valid <= 1'b0;
      stall_mode = mode;
      gaps_on = gaps;
      target = busy_items + n;
      while (busy_items < target) send_frame();
   endtask

   // receiver backpressure
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (ready_run == 0) begin
               ready_hold = ~ready_hold;
               ready_run = $urandom_range(1, 12);
            end else begin
               ready_run--;
            end
            rsp_tready <= ready_hold;
         end
      endcase
   end

   always @(posedge clock) begin : reply_check
      frame_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser != want.status) report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[31:0] != want.word)
               report_mismatch("payload_word", rsp_tdata[31:0], want.word);
            if (rsp_tdata[34:32] != want.nbytes)
               report_mismatch("valid_bytes", rsp_tdata[34:32], want.nbytes);
            if (rsp_tdata[39:35] != '0) report_mismatch("tdata pad", rsp_tdata[39:35], 32'h0);
            if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("word_frame_deframer verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CFG_HEADER_TAG;
      csr_wdata = '0;
      tag_cfg = TAG_RESET;
      term_cfg = TERM_RESET;
      frame_len = '0;
      rx_bytes = '0;
      stall_mode = 1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) push_word(script[i].word, script[i].typed, script[i].status);

      run_phase(16'hFFFF, 32'h0000_0000, 65, 2, 1'b1);
      run_phase(16'h0000, 32'hFFFF_FFFF, 65, 0, 1'b0);
      run_phase(16'($urandom), $urandom, 65, 1, 1'b1);
      run_phase(TAG_RESET, TERM_RESET, 65, 2, 1'b1);

      close_frame();
      wait_drained();
      if (pending_replies.size() != 0)
         report_mismatch("leftover transactions", pending_replies.size(), 32'h0);
      if (error_count == 0) begin
         $display("word_frame_deframer verification clean");
      end else begin
         $display("word_frame_deframer verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/wfd_pkg.sv
hw/rtl/wfd_ram.sv
hw/rtl/wfd_queue.sv
hw/rtl/wfd_front.sv
hw/rtl/wfd_back.sv
hw/rtl/word_frame_deframer.sv
tb/sv/word_frame_deframer_tb.sv
